@@ design/pdq_pkg.sv @@
// shared types and constants for the positional deque
package pdq_pkg;

    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 3;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;
    localparam int S_DATA_W    = 40;
    localparam int S_USER_W    = 3;
    localparam int M_DATA_W    = 40;
    localparam int M_USER_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_INSERT_AT  = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4,
        REQ_REMOVE_AT  = 3'd5,
        REQ_CLEAR      = 3'd6,
        REQ_NONE       = 3'd7
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic result_busy;
    } dp_status_t;

endpackage

@@ design/pdq_ctrl.sv @@
// request sequencer: takes a request, then runs it once the result slot is free
module pdq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pdq_pkg::dp_status_t dp_status,
    output pdq_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE = 2'b01,
        EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            IDLE: begin
                // nothing is taken while reset is held
                if (aresetn) begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd.capture = 1'b1;
                        state_next  = EXEC;
                    end
                end
            end
            EXEC: begin
                // wait until the previous result has been taken
                if (!dp_status.result_busy) begin
                    cmd.execute = 1'b1;
                    state_next  = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

@@ design/pdq_datapath.sv @@
// shifting cell array, element count and result register
module pdq_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pdq_pkg::ctrl_cmd_t                  cmd,
    output pdq_pkg::dp_status_t                 dp_status,
    input  logic [pdq_pkg::KIND_W-1:0]          req_type,
    input  logic signed [pdq_pkg::VALUE_W-1:0]  item_value,
    input  logic [pdq_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pdq_pkg::VALUE_W-1:0]  popped_value,
    output pdq_pkg::status_t                    status,
    output logic [pdq_pkg::COUNT_OUT_W-1:0]     element_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > pdq_pkg::POS_W) ? CW : pdq_pkg::POS_W;

    // captured request
    pdq_pkg::req_kind_t                 kind_reg;
    logic signed [pdq_pkg::VALUE_W-1:0] value_in_reg;
    logic [pdq_pkg::POS_W-1:0]          pos_reg;

    logic [pdq_pkg::VALUE_W-1:0] cell_reg  [CAPACITY];
    logic [CW-1:0]               fill_reg;
    logic [CW-1:0]               fill_next;

    logic                                out_valid_reg;
    logic signed [pdq_pkg::VALUE_W-1:0]  result_reg;
    pdq_pkg::status_t                    status_reg;
    logic [pdq_pkg::COUNT_OUT_W-1:0]     count_reg;

    logic                                do_ins;
    logic                                do_rem;
    logic [PW-1:0]                       at;
    logic [PW-1:0]                       fill_ext;
    logic [PW-1:0]                       pos_ext;
    pdq_pkg::status_t                    st;
    logic signed [pdq_pkg::VALUE_W-1:0]  result;
    logic                                is_full;
    logic                                is_empty;

    assign fill_ext = PW'(fill_reg);
    assign pos_ext  = PW'(pos_reg);
    assign is_full  = (fill_reg == CW'(CAPACITY));
    assign is_empty = (fill_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg     <= pdq_pkg::req_kind_t'(req_type);
            value_in_reg <= item_value;
            pos_reg      <= position;
        end
    end

    // decode: pick the target slot and the status
    always_comb begin
        do_ins = 1'b0;
        do_rem = 1'b0;
        at     = '0;
        st     = pdq_pkg::ST_OK;
        case (kind_reg)
            pdq_pkg::REQ_PUSH_FRONT, pdq_pkg::REQ_PUSH_BACK, pdq_pkg::REQ_INSERT_AT: begin
                if (kind_reg == pdq_pkg::REQ_PUSH_BACK) begin
                    at = fill_ext;
                end else if (kind_reg == pdq_pkg::REQ_INSERT_AT) begin
                    at = pos_ext;
                end
                if (at > fill_ext) begin
                    st = pdq_pkg::ST_BADPOS;
                end else if (is_full) begin
                    st = pdq_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            pdq_pkg::REQ_POP_FRONT, pdq_pkg::REQ_POP_BACK: begin
                if (kind_reg == pdq_pkg::REQ_POP_BACK) begin
                    at = fill_ext - PW'(1);
                end
                if (is_empty) begin
                    st = pdq_pkg::ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                end
            end
            pdq_pkg::REQ_REMOVE_AT: begin
                at = pos_ext;
                // position zero behaves as pop front, so empty wins there
                if (pos_reg == '0 && is_empty) begin
                    st = pdq_pkg::ST_EMPTY;
                end else if (pos_ext >= fill_ext) begin
                    st = pdq_pkg::ST_BADPOS;
                end else begin
                    do_rem = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (st != pdq_pkg::ST_OK) begin
            result = '1;
        end else if (do_rem) begin
            result = cell_reg[at[IW-1:0]];
        end else begin
            result = '0;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (kind_reg == pdq_pkg::REQ_CLEAR) begin
            fill_next = '0;
        end else if (do_ins) begin
            fill_next = fill_reg + CW'(1);
        end else if (do_rem) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    // each cell takes its own value, the new value, its left neighbor or its right neighbor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [pdq_pkg::VALUE_W-1:0] from_left;
        logic [pdq_pkg::VALUE_W-1:0] from_right;
        logic [pdq_pkg::VALUE_W-1:0] cell_next;
        if (i == 0) begin : g_first
            assign from_left = cell_reg[i];
        end else begin : g_mid
            assign from_left = cell_reg[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign from_right = cell_reg[i];
        end else begin : g_inner
            assign from_right = cell_reg[i+1];
        end
        always_comb begin
            cell_next = cell_reg[i];
            if (do_ins) begin
                if (PW'(i) == at) begin
                    cell_next = value_in_reg;
                end else if (PW'(i) > at) begin
                    cell_next = from_left;
                end
            end else if (do_rem) begin
                if (PW'(i) >= at) begin
                    cell_next = from_right;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (cmd.execute) begin
                cell_reg[i] <= cell_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.execute) begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            result_reg <= result;
            status_reg <= st;
            count_reg  <= pdq_pkg::COUNT_OUT_W'(fill_next);
        end
    end

    assign dp_status.result_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign popped_value  = result_reg;
    assign status        = status_reg;
    assign element_count = count_reg;

endmodule

@@ design/positional_deque_core.sv @@
// Positional deque: an ordered list of up to CAPACITY signed 32-bit values held in a row of
// shifting registers, index 0 at the front. Each request pushes at either end, inserts at a
// position, pops at either end, removes at a position or clears, and gives one result with
// the removed value (-1 on error, 0 when nothing is removed), a status and the count after
// the request. Each request is first registered, then executed, with every moving cell
// shifting at once; a new request is accepted while the previous result still waits on the
// output, but not before the previous request has been executed. Stored values need no
// clearing after reset.
module positional_deque_core #(
    parameter int CAPACITY = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // item_value [31:0], position [37:32], zero [39:38]
    input  logic [pdq_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type [2:0]
    input  logic [pdq_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // popped_value [31:0], element_count [37:32], zero [39:38]
    output logic [pdq_pkg::M_DATA_W-1:0]    m_tdata,
    // status [1:0]
    output logic [pdq_pkg::M_USER_W-1:0]    m_tuser
);

    pdq_pkg::ctrl_cmd_t                    cmd;
    pdq_pkg::dp_status_t                   dp_status;
    logic signed [pdq_pkg::VALUE_W-1:0]    popped_value;
    pdq_pkg::status_t                      status;
    logic [pdq_pkg::COUNT_OUT_W-1:0]       element_count;

    pdq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    pdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .req_type      (s_tuser[pdq_pkg::KIND_W-1:0]),
        .item_value    (s_tdata[pdq_pkg::VALUE_W-1:0]),
        .position      (s_tdata[pdq_pkg::VALUE_W +: pdq_pkg::POS_W]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .popped_value  (popped_value),
        .status        (status),
        .element_count (element_count)
    );

    assign m_tdata = {2'b00, element_count, popped_value};
    assign m_tuser = status;

`ifndef SYNTH
    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != pdq_pkg::ST_OK) |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("error result without all-ones value");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && CAPACITY < 64) |-> (m_tdata[37:32] <= 6'(CAPACITY)))
        else $error("element count above capacity");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken before the first was run");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");
`endif

endmodule

@@ tb/sv/tb_positional_deque_core.sv @@
// self-checking testbench for the positional deque core
`timescale 1ns / 100ps

module tb_positional_deque_core;

    localparam int CAPACITY       = 32;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int SETTLE_CYCLES  = 16;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [pdq_pkg::S_DATA_W-1:0]    s_tdata;
    logic [pdq_pkg::S_USER_W-1:0]    s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [pdq_pkg::M_DATA_W-1:0]    m_tdata;
    logic [pdq_pkg::M_USER_W-1:0]    m_tuser;

    typedef struct {
        logic [pdq_pkg::VALUE_W-1:0]     value;
        pdq_pkg::status_t                status;
        logic [pdq_pkg::COUNT_OUT_W-1:0] count;
    } response_t;

    // mirror of the list contents plus the responses still owed by the block
    class list_mirror;
        logic [pdq_pkg::VALUE_W-1:0] cells [CAPACITY];
        int                          held;
        response_t                   awaited_responses [$];
        int                          failures;
        int                          kind_seen [8];
        int                          status_seen [4];

        function pdq_pkg::status_t place(int at, logic [pdq_pkg::VALUE_W-1:0] value);
            if (at > held)
                return pdq_pkg::ST_BADPOS;
            if (held >= CAPACITY)
                return pdq_pkg::ST_FULL;
            for (int i = held; i > at; i--)
                cells[i] = cells[i-1];
            cells[at] = value;
            held++;
            return pdq_pkg::ST_OK;
        endfunction

        function pdq_pkg::status_t take(int at, output logic [pdq_pkg::VALUE_W-1:0] value);
            value = '0;
            if (held == 0)
                return pdq_pkg::ST_EMPTY;
            if (at >= held)
                return pdq_pkg::ST_BADPOS;
            value = cells[at];
            for (int i = at; i + 1 < held; i++)
                cells[i] = cells[i+1];
            held--;
            return pdq_pkg::ST_OK;
        endfunction

        function void note_request(pdq_pkg::req_kind_t kind,
                                   logic [pdq_pkg::VALUE_W-1:0] value,
                                   logic [pdq_pkg::POS_W-1:0] pos);
            response_t r;
            int        at;
            at       = int'(pos);
            r.value  = '0;
            r.status = pdq_pkg::ST_OK;
            case (kind)
                pdq_pkg::REQ_PUSH_FRONT: r.status = place(0, value);
                pdq_pkg::REQ_PUSH_BACK:  r.status = place(held, value);
                pdq_pkg::REQ_INSERT_AT:  r.status = place(at, value);
                pdq_pkg::REQ_POP_FRONT:  r.status = take(0, r.value);
                pdq_pkg::REQ_POP_BACK: begin
                    if (held == 0)
                        r.status = pdq_pkg::ST_EMPTY;
                    else
                        r.status = take(held - 1, r.value);
                end
                pdq_pkg::REQ_REMOVE_AT: begin
                    // position zero behaves as pop front, so an empty list reports empty
                    if (at == 0)
                        r.status = take(0, r.value);
                    else if (at >= held)
                        r.status = pdq_pkg::ST_BADPOS;
                    else
                        r.status = take(at, r.value);
                end
                pdq_pkg::REQ_CLEAR:      held = 0;
                default: ;
            endcase
            if (r.status != pdq_pkg::ST_OK)
                r.value = '1;
            r.count = held[pdq_pkg::COUNT_OUT_W-1:0];
            kind_seen[kind]++;
            status_seen[r.status]++;
            awaited_responses.push_back(r);
        endfunction

        function void check_response(logic [pdq_pkg::VALUE_W-1:0] value,
                                     logic [pdq_pkg::STATUS_W-1:0] status,
                                     logic [pdq_pkg::COUNT_OUT_W-1:0] count);
            response_t e;
            if (awaited_responses.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected response value %h status %0d count %0d",
                             $realtime, value, status, count);
                return;
            end
            e = awaited_responses.pop_front();
            if (value !== e.value || status !== e.status || count !== e.count) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $write("%0t: expected value %h status %0d count %0d, ",
                           $realtime, e.value, e.status, e.count);
                    $display("got value %h status %0d count %0d", value, status, count);
                end
            end
        endfunction
    endclass

    list_mirror mirror;
    int         burst_left;
    int         sink_hold_left;
    int         requests_sent;
    int         cycles_run;

    positional_deque_core #(
        .CAPACITY (CAPACITY)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            mirror.check_response(m_tdata[31:0], m_tuser, m_tdata[37:32]);
    end

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles_run, mirror.awaited_responses.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: stall patterns that change every so often, plus forced hold-offs
    initial begin : result_sink
        int mode;
        int span;
        int tick;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 200);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                if (sink_hold_left > 0) begin
                    m_tready <= 1'b0;
                    sink_hold_left--;
                end else begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) != 0);
                        default: m_tready <= ((tick % 5) < 2);
                    endcase
                end
            end
        end
    end

    function automatic logic [pdq_pkg::VALUE_W-1:0] any_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // offer one request in bursts with random gaps and note it once accepted
    task automatic issue(pdq_pkg::req_kind_t kind, logic [pdq_pkg::VALUE_W-1:0] value,
                         logic [pdq_pkg::POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, pos, value};
        do @(posedge aclk); while (!s_tready);
        mirror.note_request(kind, value, pos);
        requests_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (mirror.awaited_responses.size() != 0)
            @(posedge aclk);
    endtask

    task automatic fill_up();
        pdq_pkg::req_kind_t kind;
        int                 extra;
        while (mirror.held < CAPACITY) begin
            kind = pdq_pkg::req_kind_t'($urandom_range(int'(pdq_pkg::REQ_PUSH_FRONT),
                                                       int'(pdq_pkg::REQ_INSERT_AT)));
            if ($urandom_range(0, 7) == 0)
                issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, 63)));
            else
                issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, mirror.held)));
        end
        // inserts against a full list, some past the end as well
        extra = $urandom_range(1, 3);
        repeat (extra) begin
            kind = pdq_pkg::req_kind_t'($urandom_range(int'(pdq_pkg::REQ_PUSH_FRONT),
                                                       int'(pdq_pkg::REQ_INSERT_AT)));
            issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic drain_out();
        pdq_pkg::req_kind_t kind;
        int                 extra;
        while (mirror.held > 0) begin
            kind = pdq_pkg::req_kind_t'($urandom_range(int'(pdq_pkg::REQ_POP_FRONT),
                                                       int'(pdq_pkg::REQ_REMOVE_AT)));
            if ($urandom_range(0, 7) == 0)
                issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, 63)));
            else
                issue(kind, any_value(),
                      pdq_pkg::POS_W'($urandom_range(0, mirror.held - 1)));
        end
        extra = $urandom_range(1, 2);
        repeat (extra) begin
            kind = pdq_pkg::req_kind_t'($urandom_range(int'(pdq_pkg::REQ_POP_FRONT),
                                                       int'(pdq_pkg::REQ_REMOVE_AT)));
            issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, 1)));
        end
    endtask

    task automatic mixed_run(int count);
        pdq_pkg::req_kind_t kind;
        int                 r;
        repeat (count) begin
            r = $urandom_range(0, 19);
            if (r < 9)
                kind = pdq_pkg::req_kind_t'(int'(pdq_pkg::REQ_PUSH_FRONT) + r % 3);
            else if (r < 18)
                kind = pdq_pkg::req_kind_t'(int'(pdq_pkg::REQ_POP_FRONT) + r % 3);
            else if (r == 18)
                kind = pdq_pkg::REQ_CLEAR;
            else
                kind = pdq_pkg::REQ_NONE;
            if ($urandom_range(0, 3) == 0)
                issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, 63)));
            else
                issue(kind, any_value(), pdq_pkg::POS_W'($urandom_range(0, mirror.held)));
        end
    endtask

    initial begin
        int target;
        int pick;
        mirror         = new();
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        burst_left     = 0;
        sink_hold_left = 0;
        requests_sent  = 0;
        cycles_run     = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty list errors, extreme values, positions at and past the end
        issue(pdq_pkg::REQ_POP_FRONT,  32'd0,         6'd0);
        issue(pdq_pkg::REQ_POP_BACK,   32'd0,         6'd0);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd0);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd1);
        issue(pdq_pkg::REQ_INSERT_AT,  32'h1234_5678, 6'd1);
        issue(pdq_pkg::REQ_INSERT_AT,  32'h7FFF_FFFF, 6'd0);
        issue(pdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 6'd0);
        issue(pdq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 6'd63);
        issue(pdq_pkg::REQ_INSERT_AT,  32'h0000_0000, 6'd3);
        issue(pdq_pkg::REQ_INSERT_AT,  32'hA5A5_A5A5, 6'd1);
        issue(pdq_pkg::REQ_INSERT_AT,  32'h5A5A_5A5A, 6'd6);
        issue(pdq_pkg::REQ_INSERT_AT,  32'h5A5A_5A5A, 6'd63);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd2);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd4);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd32);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd63);
        issue(pdq_pkg::REQ_NONE,       32'hFFFF_FFFF, 6'd63);
        issue(pdq_pkg::REQ_POP_BACK,   32'd0,         6'd0);
        issue(pdq_pkg::REQ_POP_FRONT,  32'd0,         6'd0);
        issue(pdq_pkg::REQ_CLEAR,      32'd0,         6'd0);
        issue(pdq_pkg::REQ_CLEAR,      32'd0,         6'd0);
        issue(pdq_pkg::REQ_PUSH_BACK,  32'h5A5A_5A5A, 6'd0);
        issue(pdq_pkg::REQ_INSERT_AT,  32'h0F0F_0F0F, 6'd32);
        issue(pdq_pkg::REQ_REMOVE_AT,  32'd0,         6'd0);
        pause_until_drained();

        // back-pressure: hold the result side as the list starts to fill
        sink_hold_left = HOLD_OFF_LEN;
        fill_up();
        pause_until_drained();
        drain_out();
        pause_until_drained();

        target = requests_sent + RANDOM_ITEMS;
        while (requests_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
                fill_up();
            else if (pick < 14)
                drain_out();
            else
                mixed_run($urandom_range(20, 60));
            if ($urandom_range(0, 7) == 0)
                pause_until_drained();
            if ($urandom_range(0, 15) == 0)
                sink_hold_left = $urandom_range(40, 100);
        end

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $write("%0d requests: push front %0d, push back %0d, insert %0d, ",
               requests_sent, mirror.kind_seen[pdq_pkg::REQ_PUSH_FRONT],
               mirror.kind_seen[pdq_pkg::REQ_PUSH_BACK],
               mirror.kind_seen[pdq_pkg::REQ_INSERT_AT]);
        $display("pop front %0d, pop back %0d, remove %0d, clear %0d, unused code %0d",
                 mirror.kind_seen[pdq_pkg::REQ_POP_FRONT],
                 mirror.kind_seen[pdq_pkg::REQ_POP_BACK],
                 mirror.kind_seen[pdq_pkg::REQ_REMOVE_AT],
                 mirror.kind_seen[pdq_pkg::REQ_CLEAR],
                 mirror.kind_seen[pdq_pkg::REQ_NONE]);
        $display("statuses: ok %0d, empty %0d, bad position %0d, full %0d; %0d mismatches",
                 mirror.status_seen[pdq_pkg::ST_OK], mirror.status_seen[pdq_pkg::ST_EMPTY],
                 mirror.status_seen[pdq_pkg::ST_BADPOS],
                 mirror.status_seen[pdq_pkg::ST_FULL], mirror.failures);
        if (mirror.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
